// ===== rtl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, codes and address helpers for the picture processor CPU port.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int PATTERN_BYTES   = 8192;
    localparam int NAMETABLE_BYTES = 4096;
    localparam int SPRITE_BYTES    = 256;
    localparam int PALETTE_BYTES   = 32;

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    // Bus operation kinds.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // Register numbers.
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Where a result byte comes from once the memories have answered.
    localparam logic [1:0] SRC_IMM = 2'd0;
    localparam logic [1:0] SRC_SPR = 2'd1;
    localparam logic [1:0] SRC_BUF = 2'd2;
    localparam logic [1:0] SRC_PAL = 2'd3;

    localparam logic [1:0] MIRROR_VERT = 2'd1;

    typedef struct packed {
        logic              spr_we;
        logic              spr_re;
        logic [SPR_AW-1:0] spr_addr;
        logic              pal_we;
        logic              pal_re;
        logic [PAL_AW-1:0] pal_addr;
        logic              pat_we;
        logic              pat_re;
        logic [PAT_AW-1:0] pat_addr;
        logic              nt_we;
        logic              nt_re;
        logic [NT_AW-1:0]  nt_addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0] src;
        logic [7:0] imm;
        logic       refill;
        logic       refill_pat;
    } item_info_t;

    // Palette entries whose index is a multiple of four share storage with
    // their partner sixteen entries away, so both halves map to one row.
    function automatic logic [PAL_AW-1:0] pal_index(input logic [4:0] a);
        logic [4:0] idx;
        idx = (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a;
        return idx[PAL_AW-1:0];
    endfunction

    function automatic logic [NT_AW-1:0] nt_index(input logic [13:0] a,
                                                   input logic [1:0]  mirror);
        logic [1:0]  page;
        logic [1:0]  phys;
        logic [11:0] full;
        page = a[11:10];
        if (mirror[1]) begin
            phys = page;
        end else if (mirror == MIRROR_VERT) begin
            phys = {1'b0, page[0]};
        end else begin
            phys = {1'b0, page[1]};
        end
        full = {phys, a[9:0]};
        return full[NT_AW-1:0];
    endfunction

endpackage

// ===== rtl/ppu_ram.sv =====
// ----------------------------------------------------------------------------
// ppu_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ppu_reg_ctl.sv =====
// ----------------------------------------------------------------------------
// ppu_reg_ctl
// Register state of the CPU port and the memory commands of each bus beat.
// ----------------------------------------------------------------------------
module ppu_reg_ctl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [1:0]         op,
    input  logic [2:0]         reg_sel,
    input  logic [7:0]         data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    output ppu_pkg::mem_req_t   mem_req,
    output ppu_pkg::item_info_t info
);

    import ppu_pkg::*;

    logic [1:0]  mirror_reg;
    logic [7:0]  control_reg,  control_next;
    logic [7:0]  status_reg,   status_next;
    logic [7:0]  oam_addr_reg, oam_addr_next;
    logic [14:0] vram_reg,     vram_next;
    logic [14:0] temp_reg,     temp_next;
    logic        toggle_reg,   toggle_next;

    logic [13:0] va;
    logic [14:0] vram_step;
    logic        is_pal;

    // Mask and fine X scroll only feed rendering, which lies outside this
    // block, so their writes leave nothing to store.
    assign va        = vram_reg[13:0];
    assign is_pal    = (va >= 14'h3F00);
    assign vram_step = vram_reg + (control_reg[2] ? 15'd32 : 15'd1);

    always_comb begin
        control_next  = control_reg;
        status_next   = status_reg;
        oam_addr_next = oam_addr_reg;
        vram_next     = vram_reg;
        temp_next     = temp_reg;
        toggle_next   = toggle_reg;

        mem_req          = '0;
        mem_req.spr_addr = oam_addr_reg;
        mem_req.pal_addr = pal_index(va[4:0]);
        mem_req.pat_addr = va[PAT_AW-1:0];
        mem_req.nt_addr  = nt_index(va, mirror_reg);
        mem_req.wdata    = data;

        info            = '0;
        info.src        = SRC_IMM;
        info.refill_pat = (va < 14'h2000);

        case (op)
            OP_READ: begin
                case (reg_sel)
                    REG_STATUS: begin
                        info.imm    = status_reg;
                        status_next = {1'b0, status_reg[6:0]};
                        toggle_next = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        info.src       = SRC_SPR;
                        mem_req.spr_re = 1'b1;
                    end
                    REG_DATA: begin
                        info.src       = is_pal ? SRC_PAL : SRC_BUF;
                        info.refill    = 1'b1;
                        mem_req.pal_re = is_pal;
                        mem_req.pat_re = info.refill_pat;
                        mem_req.nt_re  = !info.refill_pat;
                        vram_next      = vram_step;
                    end
                    default: begin
                    end
                endcase
            end
            OP_WRITE: begin
                case (reg_sel)
                    REG_CTRL: begin
                        control_next     = data;
                        temp_next[11:10] = data[1:0];
                    end
                    REG_OAM_ADDR: begin
                        oam_addr_next = data;
                    end
                    REG_OAM_DATA: begin
                        mem_req.spr_we = 1'b1;
                        oam_addr_next  = oam_addr_reg + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (toggle_reg) begin
                            temp_next[14:12] = data[2:0];
                            temp_next[9:5]   = data[7:3];
                        end else begin
                            temp_next[4:0] = data[7:3];
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_ADDR: begin
                        if (toggle_reg) begin
                            temp_next = {temp_reg[14:8], data};
                            vram_next = {temp_reg[14:8], data};
                        end else begin
                            temp_next = {1'b0, data[5:0], temp_reg[7:0]};
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_DATA: begin
                        if (is_pal) begin
                            mem_req.pal_we = 1'b1;
                            mem_req.wdata  = {2'b00, data[5:0]};
                        end else if (info.refill_pat) begin
                            mem_req.pat_we = 1'b1;
                        end else begin
                            mem_req.nt_we = 1'b1;
                        end
                        vram_next = vram_step;
                    end
                    default: begin
                    end
                endcase
            end
            OP_STATUS: begin
                status_next = data;
            end
            default: begin
            end
        endcase

        if (!accept) begin
            mem_req.spr_we = 1'b0;
            mem_req.spr_re = 1'b0;
            mem_req.pal_we = 1'b0;
            mem_req.pal_re = 1'b0;
            mem_req.pat_we = 1'b0;
            mem_req.pat_re = 1'b0;
            mem_req.nt_we  = 1'b0;
            mem_req.nt_re  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg   <= '0;
            control_reg  <= '0;
            status_reg   <= '0;
            oam_addr_reg <= '0;
            vram_reg     <= '0;
            temp_reg     <= '0;
            toggle_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                mirror_reg <= cfg_data;
            end
            if (accept) begin
                control_reg  <= control_next;
                status_reg   <= status_next;
                oam_addr_reg <= oam_addr_next;
                vram_reg     <= vram_next;
                temp_reg     <= temp_next;
                toggle_reg   <= toggle_next;
            end
        end
    end

endmodule

// ===== rtl/ppu_cpu_register_port.sv =====
// ----------------------------------------------------------------------------
// ppu_cpu_register_port
// CPU-facing register port of a tile-graphics picture processor.
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_tvalid / s_tready    tdata: data, tuser: op, reg_sel
//   m_        out        m_tvalid / m_tready    tdata: read_data
//   cfg_      in         cfg_valid / cfg_ready  cfg_data: mirror_mode
//
// One beat is accepted per cycle while the output is not stalled. The
// memories are read at the edge that accepts a beat, and its result is
// loaded into the output register when the beat advances. Memory writes
// are issued in the accept cycle, so a later beat always reads the updated
// entry. Reset clears the state and valid registers; the memories hold
// undefined contents until written. A stalled output holds the pipeline.
// ----------------------------------------------------------------------------
module ppu_cpu_register_port (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data
    input  logic [4:0] s_tuser,   // [1:0] op, [4:2] reg_sel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] read_data
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    import ppu_pkg::*;

    mem_req_t   mem_req;
    item_info_t info;
    item_info_t info_reg;
    logic       v1_reg;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic [7:0] read_buffer_reg;
    logic       accept;
    logic       advance;
    logic [7:0] spr_rdata;
    logic [5:0] pal_rdata;
    logic [7:0] pat_rdata;
    logic [7:0] nt_rdata;
    logic [7:0] mem_byte;
    logic [7:0] result;

    assign advance   = v1_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !v1_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    ppu_reg_ctl u_reg_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (s_tuser[1:0]),
        .reg_sel  (s_tuser[4:2]),
        .data     (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .mem_req  (mem_req),
        .info     (info)
    );

    ppu_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spr_ram (
        .aclk  (aclk),
        .we    (mem_req.spr_we),
        .waddr (mem_req.spr_addr),
        .wdata (mem_req.wdata),
        .re    (mem_req.spr_re),
        .raddr (mem_req.spr_addr),
        .rdata (spr_rdata)
    );

    ppu_ram #(.WIDTH(6), .DEPTH(PALETTE_BYTES)) u_pal_ram (
        .aclk  (aclk),
        .we    (mem_req.pal_we),
        .waddr (mem_req.pal_addr),
        .wdata (mem_req.wdata[5:0]),
        .re    (mem_req.pal_re),
        .raddr (mem_req.pal_addr),
        .rdata (pal_rdata)
    );

    ppu_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
        .aclk  (aclk),
        .we    (mem_req.pat_we),
        .waddr (mem_req.pat_addr),
        .wdata (mem_req.wdata),
        .re    (mem_req.pat_re),
        .raddr (mem_req.pat_addr),
        .rdata (pat_rdata)
    );

    ppu_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
        .aclk  (aclk),
        .we    (mem_req.nt_we),
        .waddr (mem_req.nt_addr),
        .wdata (mem_req.wdata),
        .re    (mem_req.nt_re),
        .raddr (mem_req.nt_addr),
        .rdata (nt_rdata)
    );

    assign mem_byte = info_reg.refill_pat ? pat_rdata : nt_rdata;

    // The read buffer is updated when its beat leaves this stage, so the
    // next data-port read sees the byte fetched by this one.
    always_comb begin
        case (info_reg.src)
            SRC_SPR: result = spr_rdata;
            SRC_BUF: result = read_buffer_reg;
            SRC_PAL: result = {2'b00, pal_rdata};
            default: result = info_reg.imm;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            m_valid_reg     <= 1'b0;
            read_buffer_reg <= '0;
        end else begin
            if (s_tready) begin
                v1_reg <= accept;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                if (info_reg.refill) begin
                    read_buffer_reg <= mem_byte;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            info_reg <= info;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== test/tb_ppu_cpu_register_port.sv =====
// ----------------------------------------------------------------------------
// tb_ppu_cpu_register_port
// Self-checking bench for the CPU register port of the picture processor.
// A behavioral copy of the register file, latches and memories predicts the
// byte returned for every accepted bus beat, and the result stream is compared
// in order. Directed beats hit status, write-only reads, the sprite port and
// the palette, then random bursts of address setup and data-port traffic run
// under each mirroring mode with varying back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_ppu_cpu_register_port;
    import ppu_pkg::*;

    localparam logic [1:0] OP_NONE         = 2'd3;
    localparam logic [1:0] MIRROR_HORIZ    = 2'd0;
    localparam logic [1:0] MIRROR_FOUR     = 2'd2;
    localparam logic [1:0] MIRROR_FOUR_ALT = 2'd3;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;  // [7:0] data
    logic [4:0] s_tuser   = 5'h00;  // [1:0] op, [4:2] reg_sel
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [7:0] read_data
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = 2'd0;

    ppu_cpu_register_port dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predicted register state.
    logic [1:0]  mirror;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  status_q;
    logic [7:0]  oam_ptr;
    logic [14:0] vaddr;
    logic [14:0] taddr;
    logic [2:0]  fine_x;
    logic        second_write;
    logic [7:0]  rd_buffer;

    // Predicted memories, with a flag per entry that says it has been written.
    logic [7:0] oam_mem  [SPRITE_BYTES];
    logic [5:0] pal_mem  [PALETTE_BYTES];
    logic [7:0] pat_mem  [PATTERN_BYTES];
    logic [7:0] nt_mem   [NAMETABLE_BYTES];
    bit         oam_ok   [SPRITE_BYTES];
    bit         pal_ok   [PALETTE_BYTES];
    bit         pat_ok   [PATTERN_BYTES];
    bit         nt_ok    [NAMETABLE_BYTES];

    logic [7:0] expected_bytes[$];
    logic [7:0] want_byte;
    int         bad_bytes  = 0;
    int         beats_sent = 0;
    int         snd_idle   = 0;
    int         rcv_idle   = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("tb_ppu_cpu_register_port: FAIL");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int nt_slot(input logic [13:0] a);
        logic [1:0] page;
        logic [1:0] phys;
        page = a[11:10];
        if (mirror == MIRROR_FOUR || mirror == MIRROR_FOUR_ALT) begin
            phys = page;
        end else if (mirror == MIRROR_VERT) begin
            phys = {1'b0, page[0]};
        end else begin
            phys = {1'b0, page[1]};
        end
        return (int'(phys) * 1024 + int'(a[9:0])) % NAMETABLE_BYTES;
    endfunction

    function automatic bit cell_known(input logic [13:0] a);
        if (a < 14'h2000) begin
            return pat_ok[a[12:0]];
        end
        return nt_ok[nt_slot(a)];
    endfunction

    function automatic logic [7:0] cell_peek(input logic [13:0] a);
        if (a < 14'h2000) begin
            return pat_mem[a[12:0]];
        end
        return nt_mem[nt_slot(a)];
    endfunction

    function automatic void cell_poke(input logic [13:0] a, input logic [7:0] d);
        if (a < 14'h2000) begin
            pat_mem[a[12:0]] = d;
            pat_ok[a[12:0]]  = 1'b1;
        end else begin
            nt_mem[nt_slot(a)] = d;
            nt_ok[nt_slot(a)]  = 1'b1;
        end
    endfunction

    function automatic void advance_vaddr();
        vaddr = vaddr + (ctrl_q[2] ? 15'd32 : 15'd1);
    endfunction

    // A read must never touch an entry that was never written.
    function automatic bit read_is_safe(input logic [2:0] sel);
        logic [13:0] a;
        a = vaddr[13:0];
        if (sel == REG_OAM_DATA) begin
            return oam_ok[oam_ptr];
        end
        if (sel == REG_DATA) begin
            return cell_known(a) && (a < 14'h3F00 || pal_ok[a[4:0]]);
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] model_bus_beat(input logic [1:0] op,
                                                  input logic [2:0] sel,
                                                  input logic [7:0] d);
        logic [7:0]  r;
        logic [13:0] a;
        r = 8'h00;
        a = vaddr[13:0];
        case (op)
            OP_READ: begin
                case (sel)
                    REG_STATUS: begin
                        r            = status_q;
                        status_q[7]  = 1'b0;
                        second_write = 1'b0;
                    end
                    REG_OAM_DATA: r = oam_mem[oam_ptr];
                    REG_DATA: begin
                        // Palette reads bypass the buffer, which still refills
                        // from the nametable byte underneath.
                        if (a < 14'h3F00) begin
                            r = rd_buffer;
                        end else begin
                            r = {2'b00, pal_mem[a[4:0]]};
                        end
                        rd_buffer = cell_peek(a);
                        advance_vaddr();
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                case (sel)
                    REG_CTRL: begin
                        ctrl_q       = d;
                        taddr[11:10] = d[1:0];
                    end
                    REG_MASK:     mask_q  = d;
                    REG_OAM_ADDR: oam_ptr = d;
                    REG_OAM_DATA: begin
                        oam_mem[oam_ptr] = d;
                        oam_ok[oam_ptr]  = 1'b1;
                        oam_ptr          = oam_ptr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (second_write) begin
                            taddr[14:12] = d[2:0];
                            taddr[9:5]   = d[7:3];
                        end else begin
                            taddr[4:0] = d[7:3];
                            fine_x     = d[2:0];
                        end
                        second_write = ~second_write;
                    end
                    REG_ADDR: begin
                        if (second_write) begin
                            taddr[7:0] = d;
                            vaddr      = taddr;
                        end else begin
                            taddr[14:8] = {1'b0, d[5:0]};
                        end
                        second_write = ~second_write;
                    end
                    REG_DATA: begin
                        if (a < 14'h3F00) begin
                            cell_poke(a, d);
                        end else if (a[1:0] != 2'b00) begin
                            pal_mem[a[4:0]] = d[5:0];
                            pal_ok[a[4:0]]  = 1'b1;
                        end else begin
                            pal_mem[{1'b0, a[3:0]}] = d[5:0];
                            pal_mem[{1'b1, a[3:0]}] = d[5:0];
                            pal_ok[{1'b0, a[3:0]}]  = 1'b1;
                            pal_ok[{1'b1, a[3:0]}]  = 1'b1;
                        end
                        advance_vaddr();
                    end
                    default: ;
                endcase
            end
            OP_STATUS: status_q = d;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        bad_bytes++;
        if (bad_bytes <= 10) begin
            $display("mismatch at %0t: %s, expected %02h, got %02h",
                     $realtime, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("read_data beat with nothing pending", 8'h00, m_tdata);
            end else begin
                want_byte = expected_bytes.pop_front();
                if (m_tdata !== want_byte) begin
                    report_mismatch("read_data", want_byte, m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op, input logic [2:0] sel,
                             input logic [7:0] d);
        logic [1:0] kind;
        kind = op;
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        // A read that would reach unwritten memory becomes a write instead.
        if (kind == OP_READ && !read_is_safe(sel)) begin
            kind = OP_WRITE;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, kind};
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        expected_bytes.push_back(model_bus_beat(kind, sel, d));
        beats_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_mirror(input logic [1:0] mode);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        mirror = mode;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Clears the write toggle through a status read, then loads the address.
    task automatic point_vram(input logic [13:0] a);
        send_beat(OP_READ, REG_STATUS, 8'($urandom));
        send_beat(OP_WRITE, REG_ADDR, {2'($urandom), a[13:8]});
        send_beat(OP_WRITE, REG_ADDR, a[7:0]);
    endtask

    function automatic logic [13:0] pick_vram_addr();
        logic [13:0] a;
        case ($urandom_range(5))
            0: a = 14'h0000 + 14'($urandom_range(63));
            1: a = 14'h1FC0 + 14'($urandom_range(63));
            2: a = 14'h2000 + 14'($urandom_range(3) * 1024 + $urandom_range(63));
            3: a = ($urandom_range(1) ? 14'h2F00 : 14'h2FE0) + 14'($urandom_range(31));
            4: a = ($urandom_range(1) ? 14'h3F00 : 14'h3FE0) + 14'($urandom_range(31));
            default: a = 14'($urandom);
        endcase
        return a;
    endfunction

    task automatic run_vram_burst();
        logic [13:0] a;
        int          n;
        a = pick_vram_addr();
        n = $urandom_range(1, 8);
        point_vram(a);
        repeat (n) begin
            send_beat(($urandom_range(2) == 0) ? OP_READ : OP_WRITE, REG_DATA,
                      8'($urandom));
        end
        if ($urandom_range(1)) begin
            point_vram(a);
            repeat (n + 1) send_beat(OP_READ, REG_DATA, 8'($urandom));
        end
    endtask

    task automatic run_sprite_burst();
        logic [7:0] base;
        int         n;
        base = 8'($urandom);
        n    = $urandom_range(1, 6);
        send_beat(OP_WRITE, REG_OAM_ADDR, base);
        repeat (n) send_beat(OP_WRITE, REG_OAM_DATA, 8'($urandom));
        for (int i = 0; i < n; i++) begin
            send_beat(OP_WRITE, REG_OAM_ADDR, base + 8'(i));
            send_beat(OP_READ, REG_OAM_DATA, 8'($urandom));
        end
    endtask

    task automatic run_scroll_burst();
        send_beat(OP_READ, REG_STATUS, 8'($urandom));
        send_beat(OP_WRITE, REG_SCROLL, 8'($urandom));
        send_beat(OP_WRITE, REG_SCROLL, 8'($urandom));
        if ($urandom_range(1)) begin
            // A scroll write followed by the low address byte copies the whole
            // scroll latch, fine-Y bits included, into the VRAM address.
            send_beat(OP_WRITE, REG_SCROLL, 8'($urandom));
            send_beat(OP_WRITE, REG_ADDR, 8'($urandom));
        end
        repeat ($urandom_range(3)) begin
            send_beat($urandom_range(1) ? OP_READ : OP_WRITE, REG_DATA, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_status_register();
        send_beat(OP_STATUS, REG_CTRL, 8'hFF);
        send_beat(OP_READ, REG_STATUS, 8'h00);
        send_beat(OP_READ, REG_STATUS, 8'hFF);
        send_beat(OP_WRITE, REG_STATUS, 8'h00);
        send_beat(OP_READ, REG_STATUS, 8'h00);
    endtask

    task automatic test_write_only_reads();
        send_beat(OP_READ, REG_CTRL, 8'hFF);
        send_beat(OP_READ, REG_MASK, 8'hFF);
        send_beat(OP_READ, REG_OAM_ADDR, 8'hFF);
        send_beat(OP_READ, REG_SCROLL, 8'hFF);
        send_beat(OP_READ, REG_ADDR, 8'hFF);
        send_beat(OP_NONE, REG_DATA, 8'hFF);
    endtask

    task automatic test_sprite_port();
        // The post-increment from the top entry wraps to entry zero.
        send_beat(OP_WRITE, REG_OAM_ADDR, 8'hFF);
        send_beat(OP_WRITE, REG_OAM_DATA, 8'hA5);
        send_beat(OP_WRITE, REG_OAM_DATA, 8'h5A);
        send_beat(OP_WRITE, REG_OAM_ADDR, 8'hFF);
        send_beat(OP_READ, REG_OAM_DATA, 8'h00);
    endtask

    task automatic test_palette_and_buffer();
        send_beat(OP_WRITE, REG_ADDR, 8'h2F);
        send_beat(OP_WRITE, REG_ADDR, 8'h00);
        send_beat(OP_WRITE, REG_DATA, 8'h77);
        // Entry 0x10 shares storage with entry 0x00.
        send_beat(OP_WRITE, REG_ADDR, 8'h3F);
        send_beat(OP_WRITE, REG_ADDR, 8'h10);
        send_beat(OP_WRITE, REG_DATA, 8'hFF);
        send_beat(OP_WRITE, REG_ADDR, 8'h3F);
        send_beat(OP_WRITE, REG_ADDR, 8'h00);
        send_beat(OP_READ, REG_DATA, 8'h00);
        send_beat(OP_WRITE, REG_ADDR, 8'h2F);
        send_beat(OP_WRITE, REG_ADDR, 8'h00);
        send_beat(OP_READ, REG_DATA, 8'h00);
    endtask

    task automatic test_random_traffic(input int snd, input int rcv,
                                       input logic [1:0] mode, input int n);
        int stop_at;
        int pick;
        drain_results();
        write_mirror(mode);
        snd_idle = snd;
        rcv_idle = rcv;
        stop_at  = beats_sent + n;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                run_vram_burst();
            end else if (pick < 55) begin
                run_sprite_burst();
            end else if (pick < 65) begin
                send_beat(OP_WRITE, REG_CTRL, 8'($urandom));
                send_beat(OP_WRITE, REG_MASK, 8'($urandom));
            end else if (pick < 75) begin
                run_scroll_burst();
            end else if (pick < 82) begin
                send_beat(OP_STATUS, 3'($urandom), 8'($urandom));
                send_beat(OP_READ, REG_STATUS, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(2'($urandom), 3'($urandom), 8'($urandom));
                end
            end
            if ($urandom_range(99) < 3) begin
                drain_results();
            end
        end
    endtask

    initial begin
        mirror       = MIRROR_HORIZ;
        ctrl_q       = 8'h00;
        mask_q       = 8'h00;
        status_q     = 8'h00;
        oam_ptr      = 8'h00;
        vaddr        = 15'h0000;
        taddr        = 15'h0000;
        fine_x       = 3'd0;
        second_write = 1'b0;
        rd_buffer    = 8'h00;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_mirror(MIRROR_HORIZ);
        test_status_register();
        test_write_only_reads();
        test_sprite_port();
        test_palette_and_buffer();

        test_random_traffic(18, 69, MIRROR_VERT, 250);
        test_random_traffic(69, 18, MIRROR_FOUR_ALT, 250);
        test_random_traffic(0, 0, MIRROR_FOUR, 200);
        test_random_traffic(0, 0, MIRROR_HORIZ, 50);

        drain_results();
        repeat (8) @(posedge aclk);
        if (bad_bytes == 0) begin
            $display("tb_ppu_cpu_register_port: PASS");
        end else begin
            $display("tb_ppu_cpu_register_port: FAIL");
        end
        $finish;
    end

endmodule

// ===== ppu_cpu_register_port.f =====
rtl/ppu_pkg.sv
rtl/ppu_ram.sv
rtl/ppu_reg_ctl.sv
rtl/ppu_cpu_register_port.sv
test/tb_ppu_cpu_register_port.sv
